[rtl/osg_pkg.sv]
// ----------------------------------------------------------------------------
// osg_pkg
// shared widths, codes, register defaults and types of the offboard safety guard
// ----------------------------------------------------------------------------
`default_nettype none

package osg_pkg;

   localparam int unsigned TIME_W     = 48;
   localparam int unsigned LEVEL_W    = 16;
   localparam int unsigned BATT_W     = 15;
   localparam int unsigned POS_W      = 32;
   localparam int unsigned SQ_W       = 2 * POS_W;
   localparam int unsigned TIMEOUT_W  = 32;
   localparam int unsigned RADIUS_W   = 31;
   localparam int unsigned RSQ_W      = 2 * RADIUS_W;
   localparam int unsigned HOLDOFF_W  = 32;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CAUSE_W    = 2;

   // register defaults
   localparam logic [TIMEOUT_W-1:0] LOSS_TIMEOUT_RESET = TIMEOUT_W'(1000000);
   localparam logic [BATT_W-1:0]    BATTERY_LOW_RESET  = BATT_W'(4915);
   localparam logic [RADIUS_W-1:0]  FENCE_RADIUS_RESET = '0;
   localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET      = HOLDOFF_W'(500000);

   // evaluation queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   // result queue
   localparam int unsigned OUT_DEPTH = 2;
   localparam int unsigned OUT_PTR_W = 1;
   localparam int unsigned OUT_CNT_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOSS_TIMEOUT = 2'd0,
      CSR_BATTERY_LOW  = 2'd1,
      CSR_FENCE_RADIUS = 2'd2,
      CSR_HOLDOFF      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_LOITER = 2'd1,
      ACT_RTL    = 2'd2
   } action_type;

   localparam logic [CAUSE_W-1:0] CAUSE_LOW_BATTERY = 2'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_STALE       = 2'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_BREACH      = 2'd2;

   localparam logic CMD_LOITER = 1'b0;
   localparam logic CMD_RTL    = 1'b1;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] loss_timeout_us;
      logic [BATT_W-1:0]    battery_low_level;
      logic [RADIUS_W-1:0]  fence_radius_cm;
      logic [HOLDOFF_W-1:0] holdoff_us;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_us;
      logic              in_offboard;
      logic              stale;
      logic              batt_low;
      logic              pos_valid;
      logic [POS_W-1:0]  abs_north;
      logic [POS_W-1:0]  abs_east;
   } eval_type;

   typedef struct packed {
      logic               command;
      logic [CAUSE_W-1:0] cause;
      logic               stale_flag;
      logic               low_battery_flag;
      logic               breach_flag;
   } result_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

`default_nettype wire

[rtl/osg_front.sv]
// ----------------------------------------------------------------------------
// osg_front
// control registers, report latching and setpoint / battery classification
// ----------------------------------------------------------------------------
`default_nettype none

module osg_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   input  wire logic [osg_pkg::TIME_W-1:0]       req_now_us,
   input  wire logic                             req_setpoint_new,
   input  wire logic [osg_pkg::TIME_W-1:0]       req_setpoint_time_us,
   input  wire logic                             req_battery_new,
   input  wire logic                             req_battery_connected,
   input  wire logic signed [osg_pkg::LEVEL_W-1:0] req_battery_level,
   input  wire logic                             req_position_new,
   input  wire logic                             req_xy_valid,
   input  wire logic signed [osg_pkg::POS_W-1:0] req_north_cm,
   input  wire logic signed [osg_pkg::POS_W-1:0] req_east_cm,
   input  wire logic                             req_status_new,
   input  wire logic                             req_in_offboard,
   input  wire logic                             csr_wr_en,
   input  wire logic [osg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [osg_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire osg_pkg::queue_status_type        q_status,
   output logic                                  q_push,
   output osg_pkg::eval_type                     q_data,
   output osg_pkg::cfg_type                      cfg
);

   osg_pkg::cfg_type                  cfg_ff, cfg_in;
   logic                              held_connected_ff, held_connected_in;
   logic [osg_pkg::LEVEL_W-1:0]       held_level_ff, held_level_in;
   logic                              held_xy_valid_ff, held_xy_valid_in;
   logic [osg_pkg::POS_W-1:0]         held_north_ff, held_north_in;
   logic [osg_pkg::POS_W-1:0]         held_east_ff, held_east_in;
   logic [osg_pkg::TIME_W-1:0]        last_setpoint_ff, last_setpoint_in;
   logic                              accept;
   logic [osg_pkg::TIME_W:0]          age;
   logic                              stale_age;

   assign accept = req_push && !q_status.full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (osg_pkg::csr_index_type'(csr_index))
            osg_pkg::CSR_LOSS_TIMEOUT:
               cfg_in.loss_timeout_us = csr_wdata[osg_pkg::TIMEOUT_W-1:0];
            osg_pkg::CSR_BATTERY_LOW:
               cfg_in.battery_low_level = csr_wdata[osg_pkg::BATT_W-1:0];
            osg_pkg::CSR_FENCE_RADIUS:
               cfg_in.fence_radius_cm = csr_wdata[osg_pkg::RADIUS_W-1:0];
            osg_pkg::CSR_HOLDOFF:
               cfg_in.holdoff_us = csr_wdata[osg_pkg::HOLDOFF_W-1:0];
            default: ;
         endcase
      end
   end

   // fresh reports of this tick take part in its evaluation
   always_comb begin
      held_connected_in = held_connected_ff;
      held_level_in     = held_level_ff;
      held_xy_valid_in  = held_xy_valid_ff;
      held_north_in     = held_north_ff;
      held_east_in      = held_east_ff;
      last_setpoint_in  = last_setpoint_ff;
      if (accept && req_battery_new) begin
         held_connected_in = req_battery_connected;
         held_level_in     = req_battery_level;
      end
      if (accept && req_position_new) begin
         held_xy_valid_in = req_xy_valid;
         held_north_in    = req_north_cm;
         held_east_in     = req_east_cm;
      end
      if (accept && req_setpoint_new) begin
         last_setpoint_in = req_setpoint_time_us;
      end
   end

   // a setpoint stamped in the future has age zero
   assign age = {1'b0, req_now_us} - {1'b0, last_setpoint_in};
   assign stale_age = !age[osg_pkg::TIME_W] &&
      (age[osg_pkg::TIME_W-1:0] >
       {{(osg_pkg::TIME_W-osg_pkg::TIMEOUT_W){1'b0}}, cfg_ff.loss_timeout_us});

   always_comb begin
      q_push             = accept && req_status_new;
      q_data.now_us      = req_now_us;
      q_data.in_offboard = req_in_offboard;
      q_data.stale       = (last_setpoint_in == '0) || stale_age;
      q_data.batt_low    = held_connected_in && !held_level_in[osg_pkg::LEVEL_W-1] &&
         (held_level_in[osg_pkg::LEVEL_W-2:0] <= cfg_ff.battery_low_level);
      q_data.pos_valid   = held_xy_valid_in;
      q_data.abs_north   = held_north_in[osg_pkg::POS_W-1] ?
                           (~held_north_in + 1'b1) : held_north_in;
      q_data.abs_east    = held_east_in[osg_pkg::POS_W-1] ?
                           (~held_east_in + 1'b1) : held_east_in;
   end

   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.loss_timeout_us   <= osg_pkg::LOSS_TIMEOUT_RESET;
         cfg_ff.battery_low_level <= osg_pkg::BATTERY_LOW_RESET;
         cfg_ff.fence_radius_cm   <= osg_pkg::FENCE_RADIUS_RESET;
         cfg_ff.holdoff_us        <= osg_pkg::HOLDOFF_RESET;
         held_connected_ff        <= 1'b0;
         held_level_ff            <= '0;
         held_xy_valid_ff         <= 1'b0;
         held_north_ff            <= '0;
         held_east_ff             <= '0;
         last_setpoint_ff         <= '0;
      end else begin
         cfg_ff            <= cfg_in;
         held_connected_ff <= held_connected_in;
         held_level_ff     <= held_level_in;
         held_xy_valid_ff  <= held_xy_valid_in;
         held_north_ff     <= held_north_in;
         held_east_ff      <= held_east_in;
         last_setpoint_ff  <= last_setpoint_in;
      end
   end

endmodule

`default_nettype wire

[rtl/osg_queue.sv]
// ----------------------------------------------------------------------------
// osg_queue
// short first-in first-out buffer of classified evaluations
// ----------------------------------------------------------------------------
`default_nettype none

module osg_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire osg_pkg::eval_type  push_data,
   input  wire logic               pop,
   output osg_pkg::queue_status_type status,
   output osg_pkg::eval_type       head
);

   osg_pkg::eval_type                 entry_ff [osg_pkg::QUEUE_DEPTH];
   logic [osg_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [osg_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [osg_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                              do_push, do_pop;

   assign status.full  = (count_ff == osg_pkg::QUEUE_CNT_W'(osg_pkg::QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/osg_back.sv]
// ----------------------------------------------------------------------------
// osg_back
// geofence squares, action choice, hold-off and the result queue
// ----------------------------------------------------------------------------
`default_nettype none

module osg_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire osg_pkg::cfg_type           cfg,
   input  wire osg_pkg::queue_status_type  q_status,
   input  wire osg_pkg::eval_type          q_head,
   output logic                            q_pop,
   input  wire logic                       rsp_pop,
   output logic                            rsp_empty,
   output logic                            rsp_command,
   output logic [osg_pkg::CAUSE_W-1:0]     rsp_cause,
   output logic                            rsp_stale_flag,
   output logic                            rsp_low_battery_flag,
   output logic                            rsp_breach_flag
);

   // square stage
   logic                           sq_valid_ff, sq_valid_in;
   logic [osg_pkg::TIME_W-1:0]     sq_now_ff;
   logic                           sq_offboard_ff;
   logic                           sq_stale_ff;
   logic                           sq_low_ff;
   logic                           sq_xy_valid_ff;
   logic [osg_pkg::SQ_W-1:0]       sq_north_ff, sq_north_in;
   logic [osg_pkg::SQ_W-1:0]       sq_east_ff, sq_east_in;
   logic [osg_pkg::RSQ_W-1:0]      radius_sq_ff, radius_sq_in;
   logic                           fence_on_ff;

   // decision
   osg_pkg::action_type            prev_action_ff, prev_action_in;
   logic [osg_pkg::TIME_W-1:0]     prev_action_at_ff, prev_action_at_in;
   logic [osg_pkg::SQ_W:0]         dist_sq;
   logic                           breach;
   osg_pkg::action_type            action;
   osg_pkg::result_type            result;
   logic [osg_pkg::TIME_W:0]       since;
   logic                           within_holdoff;
   logic                           emit;
   logic                           advance;

   // result queue
   osg_pkg::result_type            out_ff [osg_pkg::OUT_DEPTH];
   logic [osg_pkg::OUT_PTR_W-1:0]  out_wr_ff, out_wr_in;
   logic [osg_pkg::OUT_PTR_W-1:0]  out_rd_ff, out_rd_in;
   logic [osg_pkg::OUT_CNT_W-1:0]  out_cnt_ff, out_cnt_in;
   logic                           out_pop;

   assign advance = (out_cnt_ff != osg_pkg::OUT_CNT_W'(osg_pkg::OUT_DEPTH));
   assign q_pop   = advance && q_status.valid;

   assign sq_valid_in  = advance ? q_status.valid : sq_valid_ff;
   assign sq_north_in  = osg_pkg::SQ_W'(q_head.abs_north) *
                         osg_pkg::SQ_W'(q_head.abs_north);
   assign sq_east_in   = osg_pkg::SQ_W'(q_head.abs_east) *
                         osg_pkg::SQ_W'(q_head.abs_east);
   assign radius_sq_in = osg_pkg::RSQ_W'(cfg.fence_radius_cm) *
                         osg_pkg::RSQ_W'(cfg.fence_radius_cm);

   assign dist_sq = {1'b0, sq_north_ff} + {1'b0, sq_east_ff};
   assign breach  = sq_xy_valid_ff && fence_on_ff &&
                    (dist_sq > {{(osg_pkg::SQ_W+1-osg_pkg::RSQ_W){1'b0}}, radius_sq_ff});

   always_comb begin
      result.stale_flag       = sq_stale_ff;
      result.low_battery_flag = sq_low_ff;
      result.breach_flag      = breach;
      if (sq_low_ff) begin
         action         = osg_pkg::ACT_RTL;
         result.command = osg_pkg::CMD_RTL;
         result.cause   = osg_pkg::CAUSE_LOW_BATTERY;
      end else if (sq_stale_ff || breach) begin
         action         = osg_pkg::ACT_LOITER;
         result.command = osg_pkg::CMD_LOITER;
         result.cause   = sq_stale_ff ? osg_pkg::CAUSE_STALE : osg_pkg::CAUSE_BREACH;
      end else begin
         action         = osg_pkg::ACT_NONE;
         result.command = osg_pkg::CMD_LOITER;
         result.cause   = osg_pkg::CAUSE_STALE;
      end
   end

   // an action time in the future counts as no time elapsed
   assign since = {1'b0, sq_now_ff} - {1'b0, prev_action_at_ff};
   assign within_holdoff = since[osg_pkg::TIME_W] ? (cfg.holdoff_us != '0) :
      (since[osg_pkg::TIME_W-1:0] <
       {{(osg_pkg::TIME_W-osg_pkg::HOLDOFF_W){1'b0}}, cfg.holdoff_us});

   assign emit = advance && sq_valid_ff && sq_offboard_ff &&
                 (action != osg_pkg::ACT_NONE) &&
                 !((prev_action_ff == action) && within_holdoff);

   always_comb begin
      prev_action_in    = prev_action_ff;
      prev_action_at_in = prev_action_at_ff;
      if (advance && sq_valid_ff && !sq_offboard_ff) begin
         prev_action_in = osg_pkg::ACT_NONE;
      end else if (emit) begin
         prev_action_in    = action;
         prev_action_at_in = sq_now_ff;
      end
   end

   assign out_pop   = rsp_pop && !rsp_empty;
   assign out_wr_in = emit ? out_wr_ff + 1'b1 : out_wr_ff;
   assign out_rd_in = out_pop ? out_rd_ff + 1'b1 : out_rd_ff;

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (emit && !out_pop) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end else if (out_pop && !emit) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end
   end

   assign rsp_empty            = (out_cnt_ff == '0);
   assign rsp_command          = out_ff[out_rd_ff].command;
   assign rsp_cause            = out_ff[out_rd_ff].cause;
   assign rsp_stale_flag       = out_ff[out_rd_ff].stale_flag;
   assign rsp_low_battery_flag = out_ff[out_rd_ff].low_battery_flag;
   assign rsp_breach_flag      = out_ff[out_rd_ff].breach_flag;

   always_ff @(posedge clock) begin
      radius_sq_ff <= radius_sq_in;
      fence_on_ff  <= (cfg.fence_radius_cm != '0);
      if (advance) begin
         sq_now_ff      <= q_head.now_us;
         sq_offboard_ff <= q_head.in_offboard;
         sq_stale_ff    <= q_head.stale;
         sq_low_ff      <= q_head.batt_low;
         sq_xy_valid_ff <= q_head.pos_valid;
         sq_north_ff    <= sq_north_in;
         sq_east_ff     <= sq_east_in;
      end
      if (emit) begin
         out_ff[out_wr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff       <= 1'b0;
         prev_action_ff    <= osg_pkg::ACT_NONE;
         prev_action_at_ff <= '0;
         out_wr_ff         <= '0;
         out_rd_ff         <= '0;
         out_cnt_ff        <= '0;
      end else begin
         sq_valid_ff       <= sq_valid_in;
         prev_action_ff    <= prev_action_in;
         prev_action_at_ff <= prev_action_at_in;
         out_wr_ff         <= out_wr_in;
         out_rd_ff         <= out_rd_in;
         out_cnt_ff        <= out_cnt_in;
      end
   end

endmodule

`default_nettype wire

[rtl/offboard_safety_guard.sv]
// a result is poppable once written to the result queue after the square stage
// throughput: one tick per cycle, set by the square stage, if result queue has room
// req_full rises when the 4-entry evaluation queue fills behind a stalled result queue
// reset (synchronous, active high) restores register defaults, clears held reports,
// setpoint time, previous action and both queues at the end of a reset cycle
// ----------------------------------------------------------------------------
// offboard_safety_guard
// checks battery, setpoint age and geofence on each status tick and issues actions
// ----------------------------------------------------------------------------
`default_nettype none

module offboard_safety_guard (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   output logic                                    req_full,
   input  wire logic [osg_pkg::TIME_W-1:0]         req_now_us,
   input  wire logic                               req_setpoint_new,
   input  wire logic [osg_pkg::TIME_W-1:0]         req_setpoint_time_us,
   input  wire logic                               req_battery_new,
   input  wire logic                               req_battery_connected,
   input  wire logic signed [osg_pkg::LEVEL_W-1:0] req_battery_level,
   input  wire logic                               req_position_new,
   input  wire logic                               req_xy_valid,
   input  wire logic signed [osg_pkg::POS_W-1:0]   req_north_cm,
   input  wire logic signed [osg_pkg::POS_W-1:0]   req_east_cm,
   input  wire logic                               req_status_new,
   input  wire logic                               req_in_offboard,
   output logic                                    rsp_empty,
   input  wire logic                               rsp_pop,
   output logic                                    rsp_command,
   output logic [osg_pkg::CAUSE_W-1:0]             rsp_cause,
   output logic                                    rsp_stale_flag,
   output logic                                    rsp_low_battery_flag,
   output logic                                    rsp_breach_flag,
   input  wire logic                               csr_wr_en,
   input  wire logic [osg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [osg_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   osg_pkg::queue_status_type q_status;
   osg_pkg::eval_type         q_data;
   osg_pkg::eval_type         q_head;
   osg_pkg::cfg_type          cfg;
   logic                      q_push;
   logic                      q_pop;

   assign req_full = q_status.full;

   osg_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_now_us            (req_now_us),
      .req_setpoint_new      (req_setpoint_new),
      .req_setpoint_time_us  (req_setpoint_time_us),
      .req_battery_new       (req_battery_new),
      .req_battery_connected (req_battery_connected),
      .req_battery_level     (req_battery_level),
      .req_position_new      (req_position_new),
      .req_xy_valid          (req_xy_valid),
      .req_north_cm          (req_north_cm),
      .req_east_cm           (req_east_cm),
      .req_status_new        (req_status_new),
      .req_in_offboard       (req_in_offboard),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .q_status              (q_status),
      .q_push                (q_push),
      .q_data                (q_data),
      .cfg                   (cfg)
   );

   osg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .status    (q_status),
      .head      (q_head)
   );

   osg_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .q_status             (q_status),
      .q_head               (q_head),
      .q_pop                (q_pop),
      .rsp_pop              (rsp_pop),
      .rsp_empty            (rsp_empty),
      .rsp_command          (rsp_command),
      .rsp_cause            (rsp_cause),
      .rsp_stale_flag       (rsp_stale_flag),
      .rsp_low_battery_flag (rsp_low_battery_flag),
      .rsp_breach_flag      (rsp_breach_flag)
   );

endmodule

`default_nettype wire

[rtl/osg_checker.sv]
// ----------------------------------------------------------------------------
// osg_port_checks
// port-level checks of the offboard safety guard, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module osg_port_checks (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_full,
   input wire logic                           rsp_empty,
   input wire logic                           rsp_pop,
   input wire logic                           rsp_command,
   input wire logic [osg_pkg::CAUSE_W-1:0]    rsp_cause,
   input wire logic                           rsp_stale_flag,
   input wire logic                           rsp_low_battery_flag,
   input wire logic                           rsp_breach_flag
);

   // return to launch only ever comes from low battery
   a_rtl_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_command == osg_pkg::CMD_RTL) |->
         (rsp_cause == osg_pkg::CAUSE_LOW_BATTERY) && rsp_low_battery_flag)
      else $error("return to launch without low battery");

   // loiter carries its cause consistent with the check flags
   a_loiter_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_command == osg_pkg::CMD_LOITER) |->
         !rsp_low_battery_flag &&
         ((rsp_cause == osg_pkg::CAUSE_STALE && rsp_stale_flag) ||
          (rsp_cause == osg_pkg::CAUSE_BREACH && !rsp_stale_flag && rsp_breach_flag)))
      else $error("loiter cause does not match flags");

   // both queues come out of reset empty: no waiting result and req_full low
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // a waiting result is not lost before its transfer
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("result dropped without transfer");

endmodule

bind offboard_safety_guard osg_port_checks u_osg_checker (
   .clock                (clock),
   .reset                (reset),
   .req_full             (req_full),
   .rsp_empty            (rsp_empty),
   .rsp_pop              (rsp_pop),
   .rsp_command          (rsp_command),
   .rsp_cause            (rsp_cause),
   .rsp_stale_flag       (rsp_stale_flag),
   .rsp_low_battery_flag (rsp_low_battery_flag),
   .rsp_breach_flag      (rsp_breach_flag)
);

`default_nettype wire
